/* hw/rtl/xbur_pkg.sv */
// Shared constants, codes and state type of the bounded uniform generator.
// No dependencies; every other file of the block imports this package.
package xbur_pkg;

    localparam int unsigned WORD_W     = 64;
    localparam int unsigned HALF_W     = 32;
    localparam int unsigned BOUND_W    = 32;
    localparam int unsigned SAMPLE_W   = 32;
    localparam int unsigned LANE_W     = 8;
    localparam int unsigned CFG_DATA_W = 64;
    localparam int unsigned CFG_ADDR_W = 4;
    localparam int unsigned GEN_WORDS  = 4;
    localparam int unsigned IDX_W      = 2;
    localparam int unsigned DIV_CNT_W  = 6;

    localparam logic [WORD_W-1:0] GOLDEN_GAMMA = 64'h9e37_79b9_7f4a_7c15;
    localparam logic [WORD_W-1:0] MIX_MUL_A    = 64'hbf58_476d_1ce4_e5b9;
    localparam logic [WORD_W-1:0] MIX_MUL_B    = 64'h94d0_49bb_1331_11eb;

    localparam int unsigned MIX_SHIFT_0 = 30;
    localparam int unsigned MIX_SHIFT_1 = 27;
    localparam int unsigned MIX_SHIFT_2 = 31;

    localparam logic OP_DRAW   = 1'b0;
    localparam logic OP_RESEED = 1'b1;

    localparam logic REG_BASE_SEED  = 1'b0;
    localparam logic REG_LANE_INDEX = 1'b1;

    localparam logic [IDX_W-1:0] LAST_WORD = IDX_W'(GEN_WORDS - 1);

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_SEED_MUL0,
        ST_SEED_MUL1,
        ST_SEED_ADD,
        ST_MIX_ADD,
        ST_MUL0,
        ST_MUL1,
        ST_MUL2,
        ST_XSHIFT,
        ST_GEN0,
        ST_GEN1,
        ST_TEST,
        ST_DIV,
        ST_OUT
    } t_state;

endpackage

/* hw/rtl/xbur_if.sv */
// Valid/ready channel interfaces: command beats in, sample beats out.
// Depends on xbur_pkg for the field widths.
interface xbur_cmd_if import xbur_pkg::*; ();
    logic               valid;
    logic               ready;
    logic               operation;
    logic [BOUND_W-1:0] bound;

    modport source (output valid, output operation, output bound, input ready);
    modport sink   (input valid, input operation, input bound, output ready);
endinterface

interface xbur_res_if import xbur_pkg::*; ();
    logic                valid;
    logic                ready;
    logic [SAMPLE_W-1:0] sample;

    modport source (output valid, output sample, input ready);
    modport sink   (input valid, input sample, output ready);
endinterface

/* hw/rtl/xoshiro_bounded_uniform_rng_core.sv */
// Top level of the bounded uniform generator: sequencer, shared 32x32 multiplier,
// bit-serial modulo unit, APB configuration registers and output register.
// Depends on xbur_pkg and the channel interfaces in xbur_if.sv.

// A draw beat with a nonzero bound runs, from one accept to the next: the accept
// cycle, the 2^64 mod bound threshold on the one-bit-per-cycle modulo unit, a
// generator step in GEN0, GEN1 and TEST (repeated for each rejected word), the
// final modulo and the hand-over of the sample to the output register, which
// waits while that register is full. A draw with bound zero goes straight to the
// output state and leaves the state alone. A reseed runs the accept cycle, then
// SEED_MUL0, SEED_MUL1 and SEED_ADD to form the seed, the four splitmix64 words
// and the hand-over of the sample. Each word passes twice through the shared 32x32
// multiplier, which forms each 64-bit constant product in three partial steps.
// After reset the block expands seed zero and stays not ready until it is done.
// The block takes one command at a time; a finished sample waits in the output
// register while the next command is accepted.
module xoshiro_bounded_uniform_rng_core
    import xbur_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    xbur_cmd_if.sink              i_cmd,
    xbur_res_if.source            o_res,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [CFG_ADDR_W-1:0] paddr,
    input  logic [CFG_DATA_W-1:0] pwdata,
    output logic [CFG_DATA_W-1:0] prdata,
    output logic                  pready
);

    t_state                r_state, n_state;
    logic [WORD_W-1:0]     r_s [GEN_WORDS];
    logic [WORD_W-1:0]     n_s [GEN_WORDS];
    logic [WORD_W-1:0]     r_acc, n_acc;
    logic [WORD_W-1:0]     r_z, n_z;
    logic [WORD_W-1:0]     r_ctr, n_ctr;
    logic [IDX_W-1:0]      r_idx, n_idx;
    logic                  r_pass, n_pass;
    logic                  r_boot, n_boot;
    logic                  r_dfin, n_dfin;
    logic [DIV_CNT_W-1:0]  r_cnt, n_cnt;
    logic [BOUND_W-1:0]    r_bnd, n_bnd;
    logic [BOUND_W-1:0]    r_thr, n_thr;
    logic [BOUND_W-1:0]    r_rem, n_rem;
    logic                  r_ovalid, n_ovalid;
    logic [SAMPLE_W-1:0]   r_sample, n_sample;
    logic [WORD_W-1:0]     r_base;
    logic [LANE_W-1:0]     r_lane;

    logic                  w_cmd_acc;
    logic                  w_out_load;
    logic                  w_cfg_wr;
    logic [HALF_W-1:0]     w_mul_a, w_mul_b;
    logic [WORD_W-1:0]     w_prod;
    logic [WORD_W-1:0]     w_mix_c;
    logic [WORD_W-1:0]     w_ctr_nx;
    logic [BOUND_W:0]      w_rem_sh;
    logic                  w_rem_ge;
    logic [BOUND_W-1:0]    w_rem_nx;
    logic [WORD_W-1:0]     w_t2, w_t3;
    logic [WORD_W-1:0]     w_rot;

    assign w_cmd_acc   = i_cmd.valid && i_cmd.ready;
    assign i_cmd.ready = (r_state == ST_IDLE);
    assign o_res.valid  = r_ovalid;
    assign o_res.sample = r_sample;
    assign w_out_load  = !r_ovalid || o_res.ready;

    // configuration port
    assign pready   = 1'b1;
    assign w_cfg_wr = psel && penable && pwrite;
    assign prdata   = (paddr[CFG_ADDR_W-1] == REG_LANE_INDEX)
                      ? {{(CFG_DATA_W-LANE_W){1'b0}}, r_lane} : r_base;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_base <= '0;
            r_lane <= '0;
        end else if (w_cfg_wr) begin
            case (paddr[CFG_ADDR_W-1])
                REG_BASE_SEED:  r_base <= pwdata;
                REG_LANE_INDEX: r_lane <= pwdata[LANE_W-1:0];
                default: ;
            endcase
        end
    end

    // shared multiplier
    assign w_mix_c = r_pass ? MIX_MUL_B : MIX_MUL_A;

    always_comb begin
        w_mul_a = r_z[HALF_W-1:0];
        w_mul_b = w_mix_c[HALF_W-1:0];
        case (r_state)
            ST_SEED_MUL0: begin
                w_mul_a = {{(HALF_W-LANE_W){1'b0}}, r_lane};
                w_mul_b = GOLDEN_GAMMA[HALF_W-1:0];
            end
            ST_SEED_MUL1: begin
                w_mul_a = {{(HALF_W-LANE_W){1'b0}}, r_lane};
                w_mul_b = GOLDEN_GAMMA[WORD_W-1:HALF_W];
            end
            ST_MUL1: begin
                w_mul_a = r_z[HALF_W-1:0];
                w_mul_b = w_mix_c[WORD_W-1:HALF_W];
            end
            ST_MUL2: begin
                w_mul_a = r_z[WORD_W-1:HALF_W];
                w_mul_b = w_mix_c[HALF_W-1:0];
            end
            default: ;
        endcase
    end

    assign w_prod = {{HALF_W{1'b0}}, w_mul_a} * {{HALF_W{1'b0}}, w_mul_b};

    // restoring modulo step, one dividend bit per cycle
    assign w_rem_sh = {r_rem, r_acc[WORD_W-1]};
    assign w_rem_ge = (w_rem_sh >= {1'b0, r_bnd});
    assign w_rem_nx = w_rem_ge ? BOUND_W'(w_rem_sh - {1'b0, r_bnd})
                               : w_rem_sh[BOUND_W-1:0];

    assign w_ctr_nx = r_ctr + GOLDEN_GAMMA;

    // generator step terms
    assign w_t2  = r_s[2] ^ r_s[0];
    assign w_t3  = r_s[3] ^ r_s[1];
    assign w_rot = {r_acc[WORD_W-8:0], r_acc[WORD_W-1:WORD_W-7]};

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (w_cmd_acc) begin
                    if (i_cmd.operation == OP_RESEED) begin
                        n_state = ST_SEED_MUL0;
                    end else if (i_cmd.bound == '0) begin
                        n_state = ST_OUT;
                    end else begin
                        n_state = ST_DIV;
                    end
                end
            end
            ST_SEED_MUL0: n_state = ST_SEED_MUL1;
            ST_SEED_MUL1: n_state = ST_SEED_ADD;
            ST_SEED_ADD:  n_state = ST_MIX_ADD;
            ST_MIX_ADD:   n_state = ST_MUL0;
            ST_MUL0:      n_state = ST_MUL1;
            ST_MUL1:      n_state = ST_MUL2;
            ST_MUL2:      n_state = ST_XSHIFT;
            ST_XSHIFT: begin
                if (!r_pass) begin
                    n_state = ST_MUL0;
                end else if (r_idx != LAST_WORD) begin
                    n_state = ST_MIX_ADD;
                end else begin
                    n_state = r_boot ? ST_IDLE : ST_OUT;
                end
            end
            ST_GEN0: n_state = ST_GEN1;
            ST_GEN1: n_state = ST_TEST;
            ST_TEST: n_state = (r_acc >= {{(WORD_W-BOUND_W){1'b0}}, r_thr}) ? ST_DIV : ST_GEN0;
            ST_DIV: begin
                if (r_cnt == '0) begin
                    n_state = r_dfin ? ST_OUT : ST_GEN0;
                end
            end
            ST_OUT: begin
                if (w_out_load) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // datapath and output register
    always_comb begin
        n_s      = r_s;
        n_acc    = r_acc;
        n_z      = r_z;
        n_ctr    = r_ctr;
        n_idx    = r_idx;
        n_pass   = r_pass;
        n_boot   = r_boot;
        n_dfin   = r_dfin;
        n_cnt    = r_cnt;
        n_bnd    = r_bnd;
        n_thr    = r_thr;
        n_rem    = r_rem;
        n_sample = r_sample;
        n_ovalid = r_ovalid && !o_res.ready;
        case (r_state)
            ST_IDLE: begin
                if (w_cmd_acc) begin
                    n_bnd  = i_cmd.bound;
                    n_rem  = '0;
                    n_cnt  = '1;
                    n_dfin = 1'b0;
                    n_acc  = '0 - {{(WORD_W-BOUND_W){1'b0}}, i_cmd.bound};
                end
            end
            ST_SEED_MUL0, ST_MUL0: begin
                n_acc = w_prod;
            end
            ST_SEED_MUL1, ST_MUL1, ST_MUL2: begin
                n_acc = {r_acc[WORD_W-1:HALF_W] + w_prod[HALF_W-1:0], r_acc[HALF_W-1:0]};
            end
            ST_SEED_ADD: begin
                n_ctr  = r_base + r_acc;
                n_idx  = '0;
                n_pass = 1'b0;
            end
            ST_MIX_ADD: begin
                n_ctr = w_ctr_nx;
                n_z   = w_ctr_nx ^ (w_ctr_nx >> MIX_SHIFT_0);
            end
            ST_XSHIFT: begin
                if (!r_pass) begin
                    n_z    = r_acc ^ (r_acc >> MIX_SHIFT_1);
                    n_pass = 1'b1;
                end else begin
                    n_s[r_idx] = r_acc ^ (r_acc >> MIX_SHIFT_2);
                    n_pass     = 1'b0;
                    n_idx      = r_idx + 1'b1;
                    if (r_idx == LAST_WORD) begin
                        n_boot = 1'b0;
                        n_rem  = '0;
                    end
                end
            end
            ST_GEN0: begin
                n_acc  = r_s[1] + {r_s[1][WORD_W-3:0], 2'b00};
                n_s[0] = r_s[0] ^ w_t3;
                n_s[1] = r_s[1] ^ w_t2;
                n_s[2] = w_t2 ^ {r_s[1][WORD_W-18:0], 17'b0};
                n_s[3] = {w_t3[WORD_W-46:0], w_t3[WORD_W-1:WORD_W-45]};
            end
            ST_GEN1: begin
                n_acc = w_rot + {w_rot[WORD_W-4:0], 3'b000};
            end
            ST_TEST: begin
                n_rem  = '0;
                n_cnt  = '1;
                n_dfin = 1'b1;
            end
            ST_DIV: begin
                n_acc = {r_acc[WORD_W-2:0], 1'b0};
                n_rem = w_rem_nx;
                n_cnt = r_cnt - 1'b1;
                if (r_cnt == '0 && !r_dfin) begin
                    n_thr = w_rem_nx;
                end
            end
            ST_OUT: begin
                if (w_out_load) begin
                    n_ovalid = 1'b1;
                    n_sample = r_rem;
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_MIX_ADD;
            r_boot   <= 1'b1;
            r_ctr    <= '0;
            r_idx    <= '0;
            r_pass   <= 1'b0;
            r_dfin   <= 1'b0;
            r_cnt    <= '0;
            r_ovalid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_boot   <= n_boot;
            r_ctr    <= n_ctr;
            r_idx    <= n_idx;
            r_pass   <= n_pass;
            r_dfin   <= n_dfin;
            r_cnt    <= n_cnt;
            r_ovalid <= n_ovalid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_s      <= n_s;
        r_acc    <= n_acc;
        r_z      <= n_z;
        r_bnd    <= n_bnd;
        r_thr    <= n_thr;
        r_rem    <= n_rem;
        r_sample <= n_sample;
    end

    a_div_bound_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_DIV) |-> (r_bnd != '0))
        else $error("modulo unit running with zero bound");

    a_rem_below_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_DIV) |-> (r_rem < r_bnd))
        else $error("partial remainder not below bound");

    a_accept_leaves_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cmd_acc |=> (r_state != ST_IDLE))
        else $error("accepted command did not start work");

    a_state_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_GEN0) |-> ((r_s[0] | r_s[1] | r_s[2] | r_s[3]) != '0))
        else $error("generator state is all zero");

endmodule

/* tb/xoshiro_bounded_uniform_rng_core_tb.sv */
// Self-checking bench for xoshiro_bounded_uniform_rng_core: draw and reseed beats,
// APB seed/lane settings, random idling and a long result hold-off.
// Depends on xbur_pkg, the channel interfaces in xbur_if.sv and the core RTL.
module xoshiro_bounded_uniform_rng_core_tb;
    import xbur_pkg::*;

    localparam int unsigned CYCLE_LIMIT = 1_000_000;
    localparam int unsigned HOLD_CYCLES = 300;

    typedef struct packed {
        logic               operation;
        logic [BOUND_W-1:0] bound;
    } t_cmd;

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  psel;
    logic                  penable;
    logic                  pwrite;
    logic [CFG_ADDR_W-1:0] paddr;
    logic [CFG_DATA_W-1:0] pwdata;
    logic [CFG_DATA_W-1:0] prdata;
    logic                  pready;

    xbur_cmd_if cmd_if ();
    xbur_res_if res_if ();

    xoshiro_bounded_uniform_rng_core u_top (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (cmd_if),
        .o_res   (res_if),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    bit [WORD_W-1:0]   gen_st [GEN_WORDS];
    bit [WORD_W-1:0]   seed_reg;
    bit [LANE_W-1:0]   lane_reg;
    t_cmd              pending_cmds [$];
    bit [SAMPLE_W-1:0] due_samples [$];
    t_cmd              cur_cmd;
    int unsigned       issued_cnt;
    int unsigned       accepted_cnt;
    int unsigned       sample_cnt;
    int unsigned       hold_left;
    bit                hold_done;
    int unsigned       err_cnt;
    int unsigned       cycle_cnt = 0;

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    always @(posedge i_clk) cycle_cnt <= cycle_cnt + 1;

    function automatic bit [WORD_W-1:0] rotl64(bit [WORD_W-1:0] v, int unsigned k);
        return (v << k) | (v >> (WORD_W - k));
    endfunction

    function automatic void expand_seed(bit [WORD_W-1:0] seed);
        bit [WORD_W-1:0] ctr;
        bit [WORD_W-1:0] z;
        ctr = seed;
        for (int i = 0; i < GEN_WORDS; i++) begin
            ctr = ctr + GOLDEN_GAMMA;
            z = ctr;
            z = (z ^ (z >> MIX_SHIFT_0)) * MIX_MUL_A;
            z = (z ^ (z >> MIX_SHIFT_1)) * MIX_MUL_B;
            gen_st[i] = z ^ (z >> MIX_SHIFT_2);
        end
    endfunction

    function automatic bit [WORD_W-1:0] gen_step();
        bit [WORD_W-1:0] raw;
        bit [WORD_W-1:0] shifted;
        raw = rotl64(gen_st[1] * 64'd5, 7) * 64'd9;
        shifted = gen_st[1] << 17;
        gen_st[2] ^= gen_st[0];
        gen_st[3] ^= gen_st[1];
        gen_st[1] ^= gen_st[2];
        gen_st[0] ^= gen_st[3];
        gen_st[2] ^= shifted;
        gen_st[3] = rotl64(gen_st[3], 45);
        return raw;
    endfunction

    function automatic bit [SAMPLE_W-1:0] draw_sample(t_cmd c);
        bit [WORD_W-1:0] n;
        bit [WORD_W-1:0] thresh;
        bit [WORD_W-1:0] raw;
        if (c.operation == OP_RESEED) begin
            expand_seed(seed_reg + WORD_W'(lane_reg) * GOLDEN_GAMMA);
            return '0;
        end
        if (c.bound == '0) begin
            return '0;
        end
        n = WORD_W'(c.bound);
        thresh = (64'd0 - n) % n;
        do begin
            raw = gen_step();
        end while (raw < thresh);
        return SAMPLE_W'(raw % n);
    endfunction

    function automatic t_cmd rand_cmd();
        t_cmd c;
        int unsigned r;
        r = $urandom_range(99);
        c.operation = OP_DRAW;
        if (r < 10) begin
            c.operation = OP_RESEED;
            c.bound = $urandom;
        end else if (r < 15) begin
            c.bound = '0;
        end else if (r < 50) begin
            c.bound = $urandom_range(300, 1);
        end else if (r < 60) begin
            c.bound = 32'd1 << $urandom_range(31);
        end else if (r < 75) begin
            c.bound = $urandom >> $urandom_range(31);
        end else begin
            c.bound = $urandom;
        end
        return c;
    endfunction

    // Driver: present queued beats, predict at acceptance
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            cmd_if.valid <= 1'b0;
        end else begin
            if (cmd_if.valid && cmd_if.ready) begin
                due_samples.push_back(draw_sample(cur_cmd));
                accepted_cnt++;
            end
            if (!cmd_if.valid || cmd_if.ready) begin
                if (pending_cmds.size() != 0 &&
                    ((accepted_cnt >= 300 && accepted_cnt < 450) ||
                     $urandom_range(99) >= 20)) begin
                    cur_cmd = pending_cmds.pop_front();
                    cmd_if.valid     <= 1'b1;
                    cmd_if.operation <= cur_cmd.operation;
                    cmd_if.bound     <= cur_cmd.bound;
                end else begin
                    cmd_if.valid <= 1'b0;
                end
            end
        end
    end

    // Hold-off: stall sample beats once for a long stretch
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            hold_left <= 0;
        end else if (hold_left != 0) begin
            hold_left <= hold_left - 1;
        end else if (sample_cnt >= 150 && !hold_done) begin
            hold_done <= 1'b1;
            hold_left <= HOLD_CYCLES;
        end
    end

    // Monitor: check sample beats, drive ready
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            res_if.ready <= 1'b0;
        end else begin
            if (res_if.valid && res_if.ready) begin
                sample_cnt++;
                if (due_samples.size() == 0) begin
                    $error("sample: expected none, actual %0d", res_if.sample);
                    err_cnt++;
                end else begin
                    bit [SAMPLE_W-1:0] exp_sample;
                    exp_sample = due_samples.pop_front();
                    if (res_if.sample !== exp_sample) begin
                        $error("sample: expected %0d, actual %0d", exp_sample, res_if.sample);
                        err_cnt++;
                    end
                end
            end
            if (hold_left != 0) begin
                res_if.ready <= 1'b0;
            end else begin
                res_if.ready <= (sample_cnt >= 500 && sample_cnt < 650) ||
                                ($urandom_range(99) >= 20);
            end
        end
    end

    task automatic queue_cmd(input logic op, input logic [BOUND_W-1:0] bnd);
        t_cmd c;
        c.operation = op;
        c.bound = bnd;
        pending_cmds.push_back(c);
        issued_cnt++;
    endtask

    task automatic drain();
        while (accepted_cnt != issued_cnt || due_samples.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic idx, input logic [CFG_DATA_W-1:0] val);
        @(posedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= CFG_ADDR_W'(idx) << 3;
        pwdata  <= val;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        if (idx == REG_BASE_SEED) seed_reg = val;
        else lane_reg = val[LANE_W-1:0];
    endtask

    initial begin
        while (cycle_cnt < CYCLE_LIMIT) @(posedge i_clk);
        $display("Test completed with failures");
        $finish;
    end

    initial begin
        cmd_if.valid     = 1'b0;
        cmd_if.operation = OP_DRAW;
        cmd_if.bound     = '0;
        res_if.ready     = 1'b0;
        psel             = 1'b0;
        penable          = 1'b0;
        pwrite           = 1'b0;
        paddr            = '0;
        pwdata           = '0;
        i_rst_n          = 1'b0;
        seed_reg         = '0;
        lane_reg         = '0;
        expand_seed('0);
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // reset seed: bound extremes, zero bound, reseed ignoring bound
        queue_cmd(OP_DRAW, 32'd0);
        queue_cmd(OP_DRAW, 32'd1);
        queue_cmd(OP_DRAW, 32'd2);
        queue_cmd(OP_DRAW, 32'hFFFF_FFFF);
        queue_cmd(OP_DRAW, 32'h8000_0000);
        queue_cmd(OP_DRAW, 32'h8000_0001);
        queue_cmd(OP_DRAW, 32'd3);
        queue_cmd(OP_DRAW, 32'h7FFF_FFFF);
        queue_cmd(OP_RESEED, 32'd0);
        queue_cmd(OP_DRAW, 32'd7);
        queue_cmd(OP_DRAW, 32'd0);
        queue_cmd(OP_RESEED, 32'hFFFF_FFFF);
        queue_cmd(OP_DRAW, 32'h0001_2345);
        drain();

        write_reg(REG_BASE_SEED, '1);
        write_reg(REG_LANE_INDEX, CFG_DATA_W'(8'hFF));
        queue_cmd(OP_DRAW, 32'd10);
        queue_cmd(OP_RESEED, 32'd5);
        queue_cmd(OP_DRAW, 32'hFFFF_FFFF);
        queue_cmd(OP_DRAW, 32'd1);
        queue_cmd(OP_DRAW, 32'h5555_5555);
        queue_cmd(OP_DRAW, 32'hAAAA_AAAA);
        drain();

        for (int ph = 0; ph < 7; ph++) begin
            case (ph)
                0: begin
                    write_reg(REG_BASE_SEED, '0);
                    write_reg(REG_LANE_INDEX, '0);
                end
                1: begin
                    write_reg(REG_LANE_INDEX, CFG_DATA_W'($urandom_range(255)));
                end
                2: begin
                    write_reg(REG_BASE_SEED, '1);
                    write_reg(REG_LANE_INDEX, '0);
                end
                default: begin
                    write_reg(REG_BASE_SEED, {$urandom, $urandom});
                    write_reg(REG_LANE_INDEX, CFG_DATA_W'($urandom_range(255)));
                end
            endcase
            queue_cmd(OP_RESEED, $urandom);
            for (int k = 1; k < 150; k++) begin
                t_cmd c;
                c = rand_cmd();
                queue_cmd(c.operation, c.bound);
            end
            drain();
        end

        repeat (150) @(posedge i_clk);
        if (err_cnt == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule
